### src/fpid_pkg.sv
// Shared constants, register codes and types of the four-axis PID core.
package fpid_pkg;

	localparam int NUM_AXES = 4;
	localparam int AXIS_X   = 0;
	localparam int AXIS_Y   = 1;
	localparam int AXIS_Z   = 2;
	localparam int AXIS_YAW = 3;

	localparam int POS_W   = 20;
	localparam int ERR_W   = 21;
	localparam int DERR_W  = 22;
	localparam int GAIN_W  = 16;
	localparam int GAINS_W = 48;
	localparam int CMD_W   = 24;
	localparam int IDX_W   = 3;

	localparam int GAIN_P_LSB = 0;
	localparam int GAIN_I_LSB = 16;
	localparam int GAIN_D_LSB = 32;

	localparam int PROD_P_W = GAIN_W + 1 + ERR_W;
	localparam int PROD_D_W = GAIN_W + 1 + DERR_W;
	localparam int PROD_I_W = GAIN_W + 1 + POS_W;
	localparam int SUM_W    = 42;
	localparam int FRAC_W   = 12;
	localparam int RND_W    = SUM_W - FRAC_W;

	localparam logic [IDX_W-1:0] REG_GAINS_XY   = 3'd0;
	localparam logic [IDX_W-1:0] REG_GAINS_Z    = 3'd1;
	localparam logic [IDX_W-1:0] REG_GAINS_YAW  = 3'd2;
	localparam logic [IDX_W-1:0] REG_TARGET_X   = 3'd3;
	localparam logic [IDX_W-1:0] REG_TARGET_Y   = 3'd4;
	localparam logic [IDX_W-1:0] REG_TARGET_Z   = 3'd5;
	localparam logic [IDX_W-1:0] REG_TARGET_YAW = 3'd6;

	localparam logic [GAINS_W-1:0] GAINS_XY_RST  = 48'd880470985114;
	localparam logic [GAINS_W-1:0] GAINS_Z_RST   = 48'd819;
	localparam logic [GAINS_W-1:0] GAINS_YAW_RST = 48'd0;
	localparam logic [POS_W-1:0]   TARGET_Z_RST  = 20'd12288;

	localparam logic signed [POS_W-1:0] XY_INTEGRAL_LIMIT   = 20'sd204800;
	localparam logic signed [POS_W-1:0] ZYAW_INTEGRAL_LIMIT = 20'sd409600;

	localparam logic signed [SUM_W-1:0] ROUND_HALF = 42'sd2048;
	localparam logic signed [RND_W-1:0] CMD_MAX    = 30'sd8388607;
	localparam logic signed [RND_W-1:0] CMD_MIN    = -30'sd8388608;

	typedef struct packed {
		logic ld1;
		logic ld2;
		logic ld3;
	} fpid_ctrl_t;

	typedef struct packed {
		logic signed [PROD_P_W-1:0] p;
		logic signed [PROD_D_W-1:0] d;
		logic signed [PROD_I_W-1:0] i;
	} fpid_prod_t;

endpackage

### src/fpid_if.sv
// Handshake channels of the PID core: pose samples, drive commands, register writes.
interface fpid_meas_if;
	logic                             valid;
	logic                             ready;
	logic signed [fpid_pkg::POS_W-1:0] meas_x;
	logic signed [fpid_pkg::POS_W-1:0] meas_y;
	logic signed [fpid_pkg::POS_W-1:0] meas_z;
	logic signed [fpid_pkg::POS_W-1:0] meas_yaw;
	modport source(output valid, meas_x, meas_y, meas_z, meas_yaw, input ready);
	modport sink(input valid, meas_x, meas_y, meas_z, meas_yaw, output ready);
endinterface

interface fpid_cmd_if;
	logic                             valid;
	logic                             ready;
	logic signed [fpid_pkg::CMD_W-1:0] cmd_x;
	logic signed [fpid_pkg::CMD_W-1:0] cmd_y;
	logic signed [fpid_pkg::CMD_W-1:0] cmd_z;
	logic signed [fpid_pkg::CMD_W-1:0] cmd_yaw;
	modport source(output valid, cmd_x, cmd_y, cmd_z, cmd_yaw, input ready);
	modport sink(input valid, cmd_x, cmd_y, cmd_z, cmd_yaw, output ready);
endinterface

interface fpid_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [fpid_pkg::IDX_W-1:0]     idx;
	logic [fpid_pkg::GAINS_W-1:0]   data;
	modport source(output valid, idx, data, input ready);
	modport sink(input valid, idx, data, output ready);
endinterface

### src/fpid_lane.sv
// One axis of the PID core: error, clamped integral, derivative and the three gain products.
module fpid_lane (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  fpid_pkg::fpid_ctrl_t                  ctrl,
	input  logic signed [fpid_pkg::POS_W-1:0]     target,
	input  logic signed [fpid_pkg::POS_W-1:0]     meas,
	input  logic [fpid_pkg::GAINS_W-1:0]          gains,
	input  logic signed [fpid_pkg::POS_W-1:0]     limit,
	output fpid_pkg::fpid_prod_t                  prod
);

	logic signed [fpid_pkg::ERR_W-1:0]  e_s1;
	logic signed [fpid_pkg::ERR_W-1:0]  e_s2;
	logic signed [fpid_pkg::DERR_W-1:0] de_s2;
	logic signed [fpid_pkg::POS_W-1:0]  acc_s2;
	logic signed [fpid_pkg::POS_W-1:0]  integ_q;
	logic signed [fpid_pkg::ERR_W-1:0]  prev_err_q;
	fpid_pkg::fpid_prod_t               prod_s3;

	logic signed [fpid_pkg::DERR_W-1:0] acc_sum;
	logic signed [fpid_pkg::DERR_W-1:0] lim_pos;
	logic signed [fpid_pkg::DERR_W-1:0] lim_neg;
	logic signed [fpid_pkg::POS_W-1:0]  acc_cl;
	logic signed [fpid_pkg::DERR_W-1:0] de;
	logic signed [fpid_pkg::GAIN_W:0]   kp;
	logic signed [fpid_pkg::GAIN_W:0]   ki;
	logic signed [fpid_pkg::GAIN_W:0]   kd;

	always_comb begin
		acc_sum = {{2{integ_q[fpid_pkg::POS_W-1]}}, integ_q} + {e_s1[fpid_pkg::ERR_W-1], e_s1};
		lim_pos = {{2{limit[fpid_pkg::POS_W-1]}}, limit};
		lim_neg = -lim_pos;
		priority if (acc_sum >= lim_pos) begin
			acc_cl = limit;
		end else if (acc_sum <= lim_neg) begin
			acc_cl = -limit;
		end else begin
			acc_cl = acc_sum[fpid_pkg::POS_W-1:0];
		end
		de = {e_s1[fpid_pkg::ERR_W-1], e_s1} - {prev_err_q[fpid_pkg::ERR_W-1], prev_err_q};
		kp = $signed({1'b0, gains[fpid_pkg::GAIN_P_LSB +: fpid_pkg::GAIN_W]});
		ki = $signed({1'b0, gains[fpid_pkg::GAIN_I_LSB +: fpid_pkg::GAIN_W]});
		kd = $signed({1'b0, gains[fpid_pkg::GAIN_D_LSB +: fpid_pkg::GAIN_W]});
	end

	// The integral and the previous error move with the item leaving stage one,
	// so the next sample in stage one always sees them already updated.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q    <= '0;
			prev_err_q <= '0;
		end else if (ctrl.ld2) begin
			integ_q    <= acc_cl;
			prev_err_q <= e_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ld1) begin
			e_s1 <= {target[fpid_pkg::POS_W-1], target} - {meas[fpid_pkg::POS_W-1], meas};
		end
		if (ctrl.ld2) begin
			e_s2   <= e_s1;
			de_s2  <= de;
			acc_s2 <= acc_cl;
		end
		if (ctrl.ld3) begin
			prod_s3.p <= kp * e_s2;
			prod_s3.d <= kd * de_s2;
			prod_s3.i <= ki * acc_s2;
		end
	end

	assign prod = prod_s3;

endmodule

### src/fpid_out.sv
// Merge stage: sums each axis's products, rounds to Q12, saturates and registers the command.
module fpid_out (
	input  logic                                              clk,
	input  logic                                              ld,
	input  fpid_pkg::fpid_prod_t [fpid_pkg::NUM_AXES-1:0]     prod,
	output logic [fpid_pkg::NUM_AXES-1:0][fpid_pkg::CMD_W-1:0] cmd_vec
);

	logic signed [fpid_pkg::SUM_W-1:0] sum     [fpid_pkg::NUM_AXES];
	logic signed [fpid_pkg::SUM_W-1:0] rnd_full[fpid_pkg::NUM_AXES];
	logic signed [fpid_pkg::RND_W-1:0] rnd     [fpid_pkg::NUM_AXES];
	logic [fpid_pkg::NUM_AXES-1:0][fpid_pkg::CMD_W-1:0] cmd_d;
	logic [fpid_pkg::NUM_AXES-1:0][fpid_pkg::CMD_W-1:0] cmd_s4;

	always_comb begin
		for (int a = 0; a < fpid_pkg::NUM_AXES; a++) begin
			sum[a] = fpid_pkg::SUM_W'(prod[a].p) + fpid_pkg::SUM_W'(prod[a].d)
				+ fpid_pkg::SUM_W'(prod[a].i);
			// Adding one half and shifting arithmetically rounds half up.
			rnd_full[a] = (sum[a] + fpid_pkg::ROUND_HALF) >>> fpid_pkg::FRAC_W;
			rnd[a] = rnd_full[a][fpid_pkg::RND_W-1:0];
			priority if (rnd[a] > fpid_pkg::CMD_MAX) begin
				cmd_d[a] = fpid_pkg::CMD_MAX[fpid_pkg::CMD_W-1:0];
			end else if (rnd[a] < fpid_pkg::CMD_MIN) begin
				cmd_d[a] = fpid_pkg::CMD_MIN[fpid_pkg::CMD_W-1:0];
			end else begin
				cmd_d[a] = rnd[a][fpid_pkg::CMD_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			cmd_s4 <= cmd_d;
		end
	end

	assign cmd_vec = cmd_s4;

endmodule

### src/four_axis_pid_with_integral_clamp_core.sv
// Top level of the four-axis positional PID core with integral clamp.
//
// Channels: meas takes one pose sample (x, y, z, yaw, Q12) per beat; cmd
// delivers one beat of four saturated Q12 drive values per sample, in order.
// cfg writes one register per beat (index 0..6: gains_xy, gains_z,
// gains_yaw, target_x..target_yaw); other indexes are ignored. cfg.ready is
// always high; writes are meant to happen only while no sample is in flight.
// A sample passes four registered stages (error, integral and
// derivative, gain products, round and saturate); cmd.valid is the
// valid bit of the last. Throughput: one sample per cycle while cmd
// is not stalled. Each axis has its own lane; the integral and previous
// error update as a sample leaves stage one, which sets that rate.
// Reset clears integrals, previous errors and the pipeline, and loads the
// default gains and targets. When cmd is stalled, the four stages keep
// taking samples until each holds one; then meas.ready drops.
module four_axis_pid_with_integral_clamp_core (
	input logic         clk,
	input logic         arst_n,
	fpid_meas_if.sink   meas,
	fpid_cmd_if.source  cmd,
	fpid_cfg_if.sink    cfg
);

	logic [fpid_pkg::GAINS_W-1:0] gains_xy_q;
	logic [fpid_pkg::GAINS_W-1:0] gains_z_q;
	logic [fpid_pkg::GAINS_W-1:0] gains_yaw_q;
	logic [fpid_pkg::POS_W-1:0]   target_x_q;
	logic [fpid_pkg::POS_W-1:0]   target_y_q;
	logic [fpid_pkg::POS_W-1:0]   target_z_q;
	logic [fpid_pkg::POS_W-1:0]   target_yaw_q;

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;
	logic ld4;
	fpid_pkg::fpid_ctrl_t ctrl;

	logic [fpid_pkg::NUM_AXES-1:0][fpid_pkg::POS_W-1:0]   target_a;
	logic [fpid_pkg::NUM_AXES-1:0][fpid_pkg::POS_W-1:0]   meas_a;
	logic [fpid_pkg::NUM_AXES-1:0][fpid_pkg::GAINS_W-1:0] gains_a;
	logic [fpid_pkg::NUM_AXES-1:0][fpid_pkg::POS_W-1:0]   limit_a;
	fpid_pkg::fpid_prod_t [fpid_pkg::NUM_AXES-1:0]        prod_a;
	logic [fpid_pkg::NUM_AXES-1:0][fpid_pkg::CMD_W-1:0]   cmd_vec;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_xy_q   <= fpid_pkg::GAINS_XY_RST;
			gains_z_q    <= fpid_pkg::GAINS_Z_RST;
			gains_yaw_q  <= fpid_pkg::GAINS_YAW_RST;
			target_x_q   <= '0;
			target_y_q   <= '0;
			target_z_q   <= fpid_pkg::TARGET_Z_RST;
			target_yaw_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.idx)
				fpid_pkg::REG_GAINS_XY:   gains_xy_q   <= cfg.data;
				fpid_pkg::REG_GAINS_Z:    gains_z_q    <= cfg.data;
				fpid_pkg::REG_GAINS_YAW:  gains_yaw_q  <= cfg.data;
				fpid_pkg::REG_TARGET_X:   target_x_q   <= cfg.data[fpid_pkg::POS_W-1:0];
				fpid_pkg::REG_TARGET_Y:   target_y_q   <= cfg.data[fpid_pkg::POS_W-1:0];
				fpid_pkg::REG_TARGET_Z:   target_z_q   <= cfg.data[fpid_pkg::POS_W-1:0];
				fpid_pkg::REG_TARGET_YAW: target_yaw_q <= cfg.data[fpid_pkg::POS_W-1:0];
				default: ;
			endcase
		end
	end

	// A stage may load when it is empty or when its item moves on this cycle.
	assign rdy4 = !v_s4 || cmd.ready;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign meas.ready = rdy1;

	assign ctrl.ld1 = meas.valid && rdy1;
	assign ctrl.ld2 = v_s1 && rdy2;
	assign ctrl.ld3 = v_s2 && rdy3;
	assign ld4      = v_s3 && rdy4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= meas.valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	always_comb begin
		target_a[fpid_pkg::AXIS_X]   = target_x_q;
		target_a[fpid_pkg::AXIS_Y]   = target_y_q;
		target_a[fpid_pkg::AXIS_Z]   = target_z_q;
		target_a[fpid_pkg::AXIS_YAW] = target_yaw_q;
		meas_a[fpid_pkg::AXIS_X]     = meas.meas_x;
		meas_a[fpid_pkg::AXIS_Y]     = meas.meas_y;
		meas_a[fpid_pkg::AXIS_Z]     = meas.meas_z;
		meas_a[fpid_pkg::AXIS_YAW]   = meas.meas_yaw;
		gains_a[fpid_pkg::AXIS_X]    = gains_xy_q;
		gains_a[fpid_pkg::AXIS_Y]    = gains_xy_q;
		gains_a[fpid_pkg::AXIS_Z]    = gains_z_q;
		gains_a[fpid_pkg::AXIS_YAW]  = gains_yaw_q;
		limit_a[fpid_pkg::AXIS_X]    = fpid_pkg::XY_INTEGRAL_LIMIT;
		limit_a[fpid_pkg::AXIS_Y]    = fpid_pkg::XY_INTEGRAL_LIMIT;
		limit_a[fpid_pkg::AXIS_Z]    = fpid_pkg::ZYAW_INTEGRAL_LIMIT;
		limit_a[fpid_pkg::AXIS_YAW]  = fpid_pkg::ZYAW_INTEGRAL_LIMIT;
	end

	for (genvar a = 0; a < fpid_pkg::NUM_AXES; a++) begin : g_lane
		fpid_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.target ($signed(target_a[a])),
			.meas   ($signed(meas_a[a])),
			.gains  (gains_a[a]),
			.limit  ($signed(limit_a[a])),
			.prod   (prod_a[a])
		);
	end

	fpid_out u_out (
		.clk     (clk),
		.ld      (ld4),
		.prod    (prod_a),
		.cmd_vec (cmd_vec)
	);

	assign cmd.valid   = v_s4;
	assign cmd.cmd_x   = $signed(cmd_vec[fpid_pkg::AXIS_X]);
	assign cmd.cmd_y   = $signed(cmd_vec[fpid_pkg::AXIS_Y]);
	assign cmd.cmd_z   = $signed(cmd_vec[fpid_pkg::AXIS_Z]);
	assign cmd.cmd_yaw = $signed(cmd_vec[fpid_pkg::AXIS_YAW]);

endmodule

### src/fpid_chk.sv
// Port-level checks of the PID core and the bind that attaches them.
module fpid_chk (
	input logic clk,
	input logic arst_n,
	input logic meas_valid,
	input logic meas_ready,
	input logic cmd_valid,
	input logic cmd_ready,
	input logic [fpid_pkg::CMD_W-1:0] cmd_x
);

	logic       in_acc;
	logic       out_acc;
	logic [2:0] pending_q;

	assign in_acc  = meas_valid && meas_ready;
	assign out_acc = cmd_valid && cmd_ready;

	// Samples accepted whose commands have not yet been taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_acc && !out_acc) begin
			pending_q <= pending_q + 3'd1;
		end else if (out_acc && !in_acc) begin
			pending_q <= pending_q - 3'd1;
		end
	end

	a_cmd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd_x))
		else $error("command beat changed while stalled");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid |-> pending_q != 3'd0)
		else $error("command beat without a pending sample");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 3'd4)
		else $error("more samples in flight than pipeline stages");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && cmd_ready ##1 cmd_ready ##1 cmd_ready ##1 cmd_ready |=> cmd_valid)
		else $error("command did not appear four cycles after the sample");

endmodule

bind four_axis_pid_with_integral_clamp_core fpid_chk u_fpid_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.meas_valid (meas.valid),
	.meas_ready (meas.ready),
	.cmd_valid  (cmd.valid),
	.cmd_ready  (cmd.ready),
	.cmd_x      (cmd.cmd_x)
);

### verif/tb.sv
// Self-checking testbench of the four-axis PID core: directed and random pose samples.
module tb;

	localparam logic [fpid_pkg::IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int PIPE_LATENCY = 4;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int PHASE_ITEMS  = 250;
	localparam int NUM_PHASES   = 5;

	typedef struct packed {
		logic signed [fpid_pkg::POS_W-1:0] x;
		logic signed [fpid_pkg::POS_W-1:0] y;
		logic signed [fpid_pkg::POS_W-1:0] z;
		logic signed [fpid_pkg::POS_W-1:0] yaw;
	} pose_t;

	typedef struct packed {
		logic signed [fpid_pkg::CMD_W-1:0] x;
		logic signed [fpid_pkg::CMD_W-1:0] y;
		logic signed [fpid_pkg::CMD_W-1:0] z;
		logic signed [fpid_pkg::CMD_W-1:0] yaw;
	} drive_t;

	logic clk = 1'b0;
	logic arst_n;

	fpid_meas_if meas_ch();
	fpid_cmd_if  cmd_ch();
	fpid_cfg_if  cfg_ch();

	four_axis_pid_with_integral_clamp_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.meas   (meas_ch),
		.cmd    (cmd_ch),
		.cfg    (cfg_ch)
	);

	// Predictor copy of the tuning registers and loop state.
	logic [fpid_pkg::GAINS_W-1:0]      gains_xy;
	logic [fpid_pkg::GAINS_W-1:0]      gains_z;
	logic [fpid_pkg::GAINS_W-1:0]      gains_yaw;
	logic signed [fpid_pkg::POS_W-1:0] setpoint [fpid_pkg::NUM_AXES];
	logic signed [fpid_pkg::POS_W-1:0] integ_acc [fpid_pkg::NUM_AXES];
	logic signed [fpid_pkg::ERR_W-1:0] last_err [fpid_pkg::NUM_AXES];

	drive_t expected_drives[$];
	int     mismatches = 0;
	int     cycle_count = 0;
	bit     idle_mode = 1'b0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic logic signed [fpid_pkg::CMD_W-1:0] axis_drive(int ax,
			logic signed [fpid_pkg::POS_W-1:0] pos, logic [fpid_pkg::GAINS_W-1:0] g,
			longint limit);
		longint err;
		longint acc;
		longint derr;
		longint sum;
		longint rnd;
		err = longint'(setpoint[ax]) - longint'(pos);
		acc = longint'(integ_acc[ax]) + err;
		if (acc >= limit)
			acc = limit;
		else if (acc <= -limit)
			acc = -limit;
		integ_acc[ax] = acc[fpid_pkg::POS_W-1:0];
		derr = err - longint'(last_err[ax]);
		last_err[ax] = err[fpid_pkg::ERR_W-1:0];
		sum = longint'(g[fpid_pkg::GAIN_P_LSB +: fpid_pkg::GAIN_W]) * err
			+ longint'(g[fpid_pkg::GAIN_D_LSB +: fpid_pkg::GAIN_W]) * derr
			+ longint'(g[fpid_pkg::GAIN_I_LSB +: fpid_pkg::GAIN_W]) * acc;
		// Round half up back to Q12, then clip to the 24-bit drive range.
		rnd = (sum + 2048) >>> fpid_pkg::FRAC_W;
		if (rnd > 64'sd8388607)
			rnd = 64'sd8388607;
		if (rnd < -64'sd8388608)
			rnd = -64'sd8388608;
		return rnd[fpid_pkg::CMD_W-1:0];
	endfunction

	function automatic drive_t predict_drive(pose_t p);
		drive_t d;
		d.x   = axis_drive(fpid_pkg::AXIS_X, p.x, gains_xy,
			longint'(fpid_pkg::XY_INTEGRAL_LIMIT));
		d.y   = axis_drive(fpid_pkg::AXIS_Y, p.y, gains_xy,
			longint'(fpid_pkg::XY_INTEGRAL_LIMIT));
		d.z   = axis_drive(fpid_pkg::AXIS_Z, p.z, gains_z,
			longint'(fpid_pkg::ZYAW_INTEGRAL_LIMIT));
		d.yaw = axis_drive(fpid_pkg::AXIS_YAW, p.yaw, gains_yaw,
			longint'(fpid_pkg::ZYAW_INTEGRAL_LIMIT));
		return d;
	endfunction

	// Drive results are accepted whenever valid and ready meet; each is matched in order.
	always @(posedge clk) begin
		drive_t got;
		drive_t want;
		if (arst_n && cmd_ch.valid && cmd_ch.ready) begin
			got = '{cmd_ch.cmd_x, cmd_ch.cmd_y, cmd_ch.cmd_z, cmd_ch.cmd_yaw};
			if (expected_drives.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected drive beat: x=%0d y=%0d z=%0d yaw=%0d",
						got.x, got.y, got.z, got.yaw);
				mismatches++;
			end else begin
				want = expected_drives.pop_front();
				if (got.x !== want.x || got.y !== want.y || got.z !== want.z
						|| got.yaw !== want.yaw) begin
					if (mismatches < 10)
						$display("drive mismatch: expected x=%0d y=%0d z=%0d yaw=%0d,",
							want.x, want.y, want.z, want.yaw,
							" got x=%0d y=%0d z=%0d yaw=%0d",
							got.x, got.y, got.z, got.yaw);
					mismatches++;
				end
			end
		end
	end

	// Result side: a random stall before each beat while idle_mode is set.
	initial begin
		int hold;
		cmd_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			hold = idle_mode ? $urandom_range(0, 6) : 0;
			if (hold > 0) begin
				cmd_ch.ready <= 1'b0;
				repeat (hold) @(negedge clk);
			end
			cmd_ch.ready <= 1'b1;
			do @(posedge clk); while (!(cmd_ch.valid && cmd_ch.ready));
		end
	end

	// All stimulus tasks start and end on a falling edge.
	task automatic send_pose(pose_t p);
		int gap;
		gap = idle_mode ? $urandom_range(0, 6) : 0;
		if (gap > 0) begin
			meas_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		meas_ch.valid    <= 1'b1;
		meas_ch.meas_x   <= p.x;
		meas_ch.meas_y   <= p.y;
		meas_ch.meas_z   <= p.z;
		meas_ch.meas_yaw <= p.yaw;
		do @(posedge clk); while (!(meas_ch.valid && meas_ch.ready));
		expected_drives.insert(expected_drives.size(), predict_drive(p));
		@(negedge clk);
	endtask

	task automatic wait_idle();
		meas_ch.valid <= 1'b0;
		do @(negedge clk); while (expected_drives.size() != 0);
		repeat (PIPE_LATENCY + 2) @(negedge clk);
	endtask

	task automatic write_reg(logic [fpid_pkg::IDX_W-1:0] idx,
			logic [fpid_pkg::GAINS_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.idx   <= idx;
		cfg_ch.data  <= data;
		do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
		case (idx)
			fpid_pkg::REG_GAINS_XY:   gains_xy = data;
			fpid_pkg::REG_GAINS_Z:    gains_z = data;
			fpid_pkg::REG_GAINS_YAW:  gains_yaw = data;
			fpid_pkg::REG_TARGET_X:   setpoint[fpid_pkg::AXIS_X] = data[fpid_pkg::POS_W-1:0];
			fpid_pkg::REG_TARGET_Y:   setpoint[fpid_pkg::AXIS_Y] = data[fpid_pkg::POS_W-1:0];
			fpid_pkg::REG_TARGET_Z:   setpoint[fpid_pkg::AXIS_Z] = data[fpid_pkg::POS_W-1:0];
			fpid_pkg::REG_TARGET_YAW: setpoint[fpid_pkg::AXIS_YAW] = data[fpid_pkg::POS_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		@(negedge clk);
	endtask

	// Writes all seven registers; setpoints carry random bits above their width.
	task automatic apply_tuning(logic [fpid_pkg::GAINS_W-1:0] gxy,
			logic [fpid_pkg::GAINS_W-1:0] gz, logic [fpid_pkg::GAINS_W-1:0] gyaw,
			pose_t tgt);
		logic [fpid_pkg::GAINS_W-fpid_pkg::POS_W-1:0] junk [fpid_pkg::NUM_AXES];
		foreach (junk[k])
			junk[k] = (fpid_pkg::GAINS_W-fpid_pkg::POS_W)'($urandom);
		write_reg(fpid_pkg::REG_GAINS_XY, gxy);
		write_reg(fpid_pkg::REG_GAINS_Z, gz);
		write_reg(fpid_pkg::REG_GAINS_YAW, gyaw);
		write_reg(fpid_pkg::REG_TARGET_X, {junk[0], tgt.x});
		write_reg(fpid_pkg::REG_TARGET_Y, {junk[1], tgt.y});
		write_reg(fpid_pkg::REG_TARGET_Z, {junk[2], tgt.z});
		write_reg(fpid_pkg::REG_TARGET_YAW, {junk[3], tgt.yaw});
	endtask

	function automatic logic [fpid_pkg::GAINS_W-1:0] rand_gains();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		// Mostly modest gains so that the outputs are not all clipped.
		if ($urandom_range(0, 3) != 0)
			return {16'($urandom_range(0, 8191)), 16'($urandom_range(0, 511)),
				16'($urandom_range(0, 8191))};
		return raw[fpid_pkg::GAINS_W-1:0];
	endfunction

	function automatic logic signed [fpid_pkg::POS_W-1:0] rand_target();
		int offset;
		offset = int'($urandom_range(0, 131072)) - 65536;
		if ($urandom_range(0, 9) < 7)
			return offset[fpid_pkg::POS_W-1:0];
		return fpid_pkg::POS_W'($urandom);
	endfunction

	// Positions mostly track the setpoint closely, with some wide jumps and extremes.
	function automatic logic signed [fpid_pkg::POS_W-1:0] rand_coord(
			logic signed [fpid_pkg::POS_W-1:0] tgt);
		int kind;
		int delta;
		kind  = $urandom_range(0, 99);
		delta = int'($urandom_range(0, 32768)) - 16384;
		if (kind < 65)
			return tgt + delta[fpid_pkg::POS_W-1:0];
		else if (kind < 90)
			return fpid_pkg::POS_W'($urandom);
		else if (kind < 95)
			return 20'sd524287;
		return -20'sd524288;
	endfunction

	task automatic test_reset_defaults();
		idle_mode = 1'b1;
		send_pose('{20'sd0, 20'sd0, 20'sd0, 20'sd0});
		send_pose('{20'sd524287, 20'sd524287, 20'sd524287, 20'sd524287});
		send_pose('{-20'sd524288, -20'sd524288, -20'sd524288, -20'sd524288});
		wait_idle();
	endtask

	task automatic test_output_saturation();
		apply_tuning('1, '1, '1, '{20'sd524287, -20'sd524288, 20'sd524287, -20'sd524288});
		send_pose('{-20'sd524288, 20'sd524287, -20'sd524288, 20'sd524287});
		send_pose('{20'sd524287, -20'sd524288, 20'sd524287, -20'sd524288});
		send_pose('{20'sd0, 20'sd0, 20'sd0, 20'sd0});
		wait_idle();
	endtask

	// With a unit integral gain only, each drive equals the clamped integral.
	task automatic test_integral_clamp();
		apply_tuning({16'd0, 16'd4096, 16'd0}, {16'd0, 16'd4096, 16'd0},
			{16'd0, 16'd4096, 16'd0}, '{20'sd0, 20'sd0, 20'sd0, 20'sd0});
		repeat (3)
			send_pose('{-20'sd200000, -20'sd200000, -20'sd200000, -20'sd200000});
		send_pose('{20'sd524287, 20'sd524287, 20'sd524287, 20'sd524287});
		send_pose('{20'sd524287, 20'sd524287, 20'sd524287, 20'sd524287});
		send_pose('{20'sd0, 20'sd0, 20'sd0, 20'sd0});
		wait_idle();
	endtask

	task automatic test_ignored_index();
		write_reg(REG_UNUSED, '1);
		send_pose('{20'sd4096, -20'sd4096, 20'sd8192, 20'sd1});
		wait_idle();
	endtask

	task automatic test_random_tuning();
		pose_t tgt;
		pose_t p;
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0: begin
					tgt = '{20'sd524287, 20'sd524287, 20'sd524287, 20'sd524287};
					apply_tuning('1, '1, '1, tgt);
				end
				1: begin
					tgt = '{-20'sd524288, -20'sd524288, -20'sd524288, -20'sd524288};
					apply_tuning('0, '0, '0, tgt);
				end
				default: begin
					tgt = '{rand_target(), rand_target(), rand_target(), rand_target()};
					apply_tuning(rand_gains(), rand_gains(), rand_gains(), tgt);
				end
			endcase
			idle_mode = (ph != 3);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				p.x   = rand_coord(tgt.x);
				p.y   = rand_coord(tgt.y);
				p.z   = rand_coord(tgt.z);
				p.yaw = rand_coord(tgt.yaw);
				send_pose(p);
				// Hold the sender once mid-phase until the pipeline has emptied.
				if (ph == 2 && n == PHASE_ITEMS / 2)
					wait_idle();
			end
			wait_idle();
		end
	endtask

	initial begin
		arst_n           = 1'b0;
		meas_ch.valid    = 1'b0;
		meas_ch.meas_x   = '0;
		meas_ch.meas_y   = '0;
		meas_ch.meas_z   = '0;
		meas_ch.meas_yaw = '0;
		cfg_ch.valid     = 1'b0;
		cfg_ch.idx       = '0;
		cfg_ch.data      = '0;
		gains_xy  = fpid_pkg::GAINS_XY_RST;
		gains_z   = fpid_pkg::GAINS_Z_RST;
		gains_yaw = fpid_pkg::GAINS_YAW_RST;
		foreach (setpoint[k]) begin
			setpoint[k]  = '0;
			integ_acc[k] = '0;
			last_err[k]  = '0;
		end
		setpoint[fpid_pkg::AXIS_Z] = fpid_pkg::TARGET_Z_RST;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_defaults();
		test_output_saturation();
		test_integral_clamp();
		test_ignored_index();
		test_random_tuning();

		wait_idle();
		if (mismatches == 0 && expected_drives.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
